// File: rtl/core/aec_pkg.sv
// ----------------------------------------------------------------------------
// Audio effects chain package
// Shared widths, register indexes, controller states, datapath commands and
// the soft clip table.
// ----------------------------------------------------------------------------
package aec_pkg;

	localparam int DELAY_DEPTH        = 65536;
	localparam int SAMPLE_WIDTH       = 24;
	localparam int CLIP_TABLE_ENTRIES = 1024;

	localparam int FRAC      = SAMPLE_WIDTH - 1;
	localparam int MEM_W     = SAMPLE_WIDTH + 4;
	localparam int X_W       = SAMPLE_WIDTH + 2;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 14;
	localparam int DLEN_W    = 17;
	localparam int CFG_W     = 17;
	localparam int IDX_W     = 3;

	localparam int POS_W     = $clog2(DELAY_DEPTH);
	localparam int CNT_W     = $clog2(DELAY_DEPTH + 1);
	localparam int LEN_CMP_W = (CNT_W > DLEN_W) ? CNT_W : DLEN_W;
	localparam int CIDX_W    = $clog2(CLIP_TABLE_ENTRIES);
	localparam int TIDX_W    = $clog2(CLIP_TABLE_ENTRIES + 1);

	// Comb mix coefficients, Q16 forms of 0.7 and 0.3.
	localparam int MIX_IN_COEF  = 45875;
	localparam int MIX_DLY_COEF = 19661;
	localparam int MIX_SHIFT    = 16;
	localparam int COEF_W       = 17;

	typedef enum logic [IDX_W-1:0] {
		REG_EQ_ENABLE,
		REG_EQ_GAIN,
		REG_CLIP_ENABLE,
		REG_DELAY_ENABLE,
		REG_DELAY_LENGTH,
		REG_OUTPUT_GAIN
	} reg_idx_t;

	typedef struct packed {
		logic              eq_enable;
		logic [GAIN_W-1:0] eq_gain;
		logic              clip_enable;
		logic              delay_enable;
		logic [DLEN_W-1:0] delay_length;
		logic [GAIN_W-1:0] output_gain;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EQ,
		ST_CLIP_RD,
		ST_CLIP_MIX,
		ST_DLY,
		ST_MIX,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic eq;
		logic clip_rd;
		logic clip_mix;
		logic dly;
		logic mix;
		logic out;
	} dp_cmd_t;

	typedef logic [FRAC-1:0] clip_tab_t [0:CLIP_TABLE_ENTRIES];

	// Shift-and-subtract quotient of two non-negative values, used only while
	// the table is built at elaboration.
	function automatic longint div_floor_pos(longint n, longint d);
		longint q;
		longint rem;
		q   = 0;
		rem = 0;
		for (int i = 62; i >= 0; i--) begin
			rem = (rem << 1) | ((n >>> i) & longint'(1));
			if (rem >= d) begin
				rem = rem - d;
				q   = q | (longint'(1) << i);
			end
		end
		return q;
	endfunction

	// Builds tanh(5x)/tanh(5) samples in Q30 integer arithmetic at elaboration.
	function automatic clip_tab_t build_clip_table();
		clip_tab_t tab;
		longint    q30;
		longint    u;
		longint    term;
		longint    r;
		longint    e;
		longint    en;
		longint    num;
		longint    den;
		longint    t;
		longint    cap;
		q30  = longint'(1) << 30;
		u    = (longint'(10) << 30) / CLIP_TABLE_ENTRIES;
		term = q30;
		r    = q30;
		cap  = (longint'(1) << FRAC) - 1;
		for (int k = 1; k <= 12; k++) begin
			term = div_floor_pos((term * u) >>> 30, longint'(k));
			if ((k & 1) != 0) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		en = q30;
		for (int i = 1; i <= CLIP_TABLE_ENTRIES; i++) begin
			en = (en * r + (q30 >>> 1)) >>> 30;
		end
		e = q30;
		for (int i = 0; i <= CLIP_TABLE_ENTRIES; i++) begin
			if (i > 0) begin
				e = (e * r + (q30 >>> 1)) >>> 30;
			end
			num = ((q30 - e) * (q30 + en)) >>> 30;
			den = ((q30 + e) * (q30 - en)) >>> 30;
			if (den == 0) begin
				den = 1;
			end
			t = div_floor_pos((num << FRAC) + (den >>> 1), den);
			tab[i] = FRAC'((t > cap) ? cap : t);
		end
		return tab;
	endfunction

	localparam clip_tab_t CLIP_TABLE = build_clip_table();

endpackage

// File: rtl/core/aec_in_if.sv
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel that carries one audio sample per transaction.
// ----------------------------------------------------------------------------
interface aec_in_if
	import aec_pkg::*;
();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// File: rtl/core/aec_out_if.sv
// ----------------------------------------------------------------------------
// Sample result channel
// Valid/ready channel that carries one processed sample and its saturation flag.
// ----------------------------------------------------------------------------
interface aec_out_if
	import aec_pkg::*;
();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

// File: rtl/core/aec_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// File: rtl/core/aec_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file for the gain, clip and delay settings.
// ----------------------------------------------------------------------------
module aec_cfg
	import aec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	output cfg_t             cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eq_enable    <= 1'b0;
			cfg_q.eq_gain      <= GAIN_W'(16384);
			cfg_q.clip_enable  <= 1'b0;
			cfg_q.delay_enable <= 1'b0;
			cfg_q.delay_length <= DLEN_W'(44100);
			cfg_q.output_gain  <= GAIN_W'(12288);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EQ_ENABLE:    cfg_q.eq_enable    <= wr_data[0];
				REG_EQ_GAIN:      cfg_q.eq_gain      <= wr_data[GAIN_W-1:0];
				REG_CLIP_ENABLE:  cfg_q.clip_enable  <= wr_data[0];
				REG_DELAY_ENABLE: cfg_q.delay_enable <= wr_data[0];
				REG_DELAY_LENGTH: cfg_q.delay_length <= wr_data[DLEN_W-1:0];
				REG_OUTPUT_GAIN:  cfg_q.output_gain  <= wr_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// File: rtl/core/aec_ctrl.sv
// ----------------------------------------------------------------------------
// Audio effects chain controller
// Sequences the datapath steps for one sample and owns the result valid flag.
// ----------------------------------------------------------------------------
module aec_ctrl
	import aec_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);
	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EQ;
				end
			end
			ST_EQ: begin
				cmd.eq  = 1'b1;
				state_d = ST_CLIP_RD;
			end
			ST_CLIP_RD: begin
				cmd.clip_rd = 1'b1;
				state_d     = ST_CLIP_MIX;
			end
			ST_CLIP_MIX: begin
				cmd.clip_mix = 1'b1;
				state_d      = ST_DLY;
			end
			ST_DLY: begin
				cmd.dly = 1'b1;
				state_d = ST_MIX;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// The result register is free once its transaction completes.
				if (!out_valid_q || out_ready) begin
					cmd.out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

// File: rtl/core/aec_dp.sv
// ----------------------------------------------------------------------------
// Audio effects chain datapath
// EQ gain, table soft clip, feedback comb delay and output gain on one sample.
// ----------------------------------------------------------------------------
module aec_dp
	import aec_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  dp_cmd_t                        cmd,
	input  cfg_t                           cfg,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           clipped
);
	localparam int EQP_W  = SAMPLE_WIDTH + GAIN_W + 1;
	localparam int POSP_W = FRAC + TIDX_W;
	localparam int DIFF_W = FRAC + 1;
	localparam int INTP_W = 2 * FRAC + 2;
	localparam int PX_W   = X_W + COEF_W;
	localparam int PD_W   = MEM_W + COEF_W;
	localparam int MIX_W  = ((PX_W > PD_W) ? PX_W : PD_W) + 1;
	localparam int OP_W   = MEM_W + GAIN_W + 1;
	localparam int OV_W   = OP_W - GAIN_FRAC;

	localparam logic [X_W-1:0]           FULL  = X_W'((longint'(1) << FRAC) - 1);
	localparam logic signed [MEM_W:0]    M_HI  = (MEM_W+1)'((longint'(1) << (MEM_W-1)) - 1);
	localparam logic signed [MEM_W:0]    M_LO  = (MEM_W+1)'(-(longint'(1) << (MEM_W-1)));
	localparam logic signed [OV_W-1:0]   O_HI  = OV_W'((longint'(1) << (SAMPLE_WIDTH-1)) - 1);
	localparam logic signed [OV_W-1:0]   O_LO  = OV_W'(-(longint'(1) << (SAMPLE_WIDTH-1)));

	// Working registers.
	logic signed [X_W-1:0]          x_q;
	logic [FRAC-1:0]                a_q;
	logic [FRAC-1:0]                b_q;
	logic [FRAC-1:0]                fr_q;
	logic                           neg_q;
	logic                           big_q;
	logic signed [PX_W-1:0]         px_q;
	logic signed [PD_W-1:0]         pd_q;
	logic signed [MEM_W-1:0]        v_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	// Delay position and high-water mark of written entries.
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] hwm_q;

	// EQ gain.
	logic signed [EQP_W-1:0] eq_sum;
	assign eq_sum = $signed(x_q[SAMPLE_WIDTH-1:0]) * $signed({1'b0, cfg.eq_gain})
		+ EQP_W'(1 << (GAIN_FRAC - 1));

	// Soft clip table lookup.
	logic [X_W-1:0]    mag;
	logic [POSP_W-1:0] tpos;
	logic [TIDX_W-1:0] tidx;
	assign mag  = x_q[X_W-1] ? X_W'(-x_q) : X_W'(x_q);
	assign tpos = POSP_W'(mag[FRAC-1:0]) * POSP_W'(CLIP_TABLE_ENTRIES);
	assign tidx = TIDX_W'(tpos[FRAC +: CIDX_W]);

	// Soft clip interpolation.
	logic signed [DIFF_W-1:0] diff;
	logic signed [INTP_W-1:0] intp;
	logic signed [DIFF_W:0]   ysum;
	logic [FRAC-1:0]          ymag;
	assign diff = $signed({1'b0, b_q}) - $signed({1'b0, a_q});
	assign intp = diff * $signed({1'b0, fr_q}) + INTP_W'(longint'(1) << (FRAC - 1));
	assign ysum = $signed({2'b00, a_q}) + (DIFF_W+1)'(intp[FRAC +: DIFF_W]);
	assign ymag = big_q ? FULL[FRAC-1:0] : ysum[FRAC-1:0];

	// Comb delay addressing. A stale position restarts at zero.
	logic [CNT_W-1:0] len_eff;
	logic [POS_W-1:0] pos_eff;
	logic [CNT_W-1:0] pos_inc;
	logic             d_valid;
	always_comb begin
		if (cfg.delay_length == '0) begin
			len_eff = CNT_W'(1);
		end else if (LEN_CMP_W'(cfg.delay_length) > LEN_CMP_W'(DELAY_DEPTH)) begin
			len_eff = CNT_W'(DELAY_DEPTH);
		end else begin
			len_eff = CNT_W'(cfg.delay_length);
		end
	end
	assign pos_eff = (CNT_W'(pos_q) >= len_eff) ? '0 : pos_q;
	assign pos_inc = CNT_W'(pos_eff) + CNT_W'(1);
	// Entries at or above the high-water mark have never been written and read as zero.
	assign d_valid = CNT_W'(pos_eff) < hwm_q;

	logic [MEM_W-1:0]        rd_data;
	logic signed [MEM_W-1:0] dly;
	logic signed [MEM_W:0]   d_half;
	logic signed [MEM_W:0]   wsum;
	logic signed [MEM_W-1:0] wval;
	assign dly    = d_valid ? $signed(rd_data) : '0;
	assign d_half = ((MEM_W+1)'(dly) + (MEM_W+1)'(1)) >>> 1;
	assign wsum   = (MEM_W+1)'(x_q) + d_half;
	always_comb begin
		if (wsum > M_HI) begin
			wval = M_HI[MEM_W-1:0];
		end else if (wsum < M_LO) begin
			wval = M_LO[MEM_W-1:0];
		end else begin
			wval = wsum[MEM_W-1:0];
		end
	end

	aec_ram #(
		.WIDTH(MEM_W),
		.DEPTH(DELAY_DEPTH)
	) u_dly_ram (
		.clk     (clk),
		.we      (cmd.dly && cfg.delay_enable),
		.wr_addr (pos_eff),
		.wr_data (wval),
		.re      (cmd.clip_mix),
		.rd_addr (pos_eff),
		.rd_data (rd_data)
	);

	// Comb mix.
	logic signed [MIX_W-1:0] msum;
	assign msum = MIX_W'(px_q) + MIX_W'(pd_q) + MIX_W'(1 << (MIX_SHIFT - 1));

	// Output gain and saturation.
	logic signed [OP_W-1:0] oprod;
	logic signed [OV_W-1:0] oval;
	assign oprod = v_q * $signed({1'b0, cfg.output_gain}) + OP_W'(1 << (GAIN_FRAC - 1));
	assign oval  = oprod[GAIN_FRAC +: OV_W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= X_W'(sample_in);
		end
		if (cmd.eq && cfg.eq_enable) begin
			x_q <= eq_sum[GAIN_FRAC +: X_W];
		end
		if (cmd.clip_rd) begin
			a_q   <= CLIP_TABLE[tidx];
			b_q   <= CLIP_TABLE[tidx + TIDX_W'(1)];
			fr_q  <= tpos[FRAC-1:0];
			neg_q <= x_q[X_W-1];
			big_q <= mag > FULL;
		end
		if (cmd.clip_mix && cfg.clip_enable) begin
			x_q <= neg_q ? -$signed(X_W'(ymag)) : $signed(X_W'(ymag));
		end
		if (cmd.dly) begin
			px_q <= x_q * $signed(COEF_W'(MIX_IN_COEF));
			pd_q <= dly * $signed(COEF_W'(MIX_DLY_COEF));
		end
		if (cmd.mix) begin
			v_q <= cfg.delay_enable ? msum[MIX_SHIFT +: MEM_W] : MEM_W'(x_q);
		end
		if (cmd.out) begin
			if (oval > O_HI) begin
				sample_out_q <= O_HI[SAMPLE_WIDTH-1:0];
				clipped_q    <= 1'b1;
			end else if (oval < O_LO) begin
				sample_out_q <= O_LO[SAMPLE_WIDTH-1:0];
				clipped_q    <= 1'b1;
			end else begin
				sample_out_q <= oval[SAMPLE_WIDTH-1:0];
				clipped_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hwm_q <= '0;
		end else if (cmd.dly && cfg.delay_enable) begin
			pos_q <= (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
			if (CNT_W'(pos_eff) == hwm_q) begin
				hwm_q <= hwm_q + CNT_W'(1);
			end
		end
	end

	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;
endmodule

// File: rtl/core/audio_effects_chain.sv
// ----------------------------------------------------------------------------
// Audio effects chain
// EQ gain, tanh soft clip, feedback comb delay and output gain per sample.
// ----------------------------------------------------------------------------
// Each accepted sample passes through the accepting cycle and six steps of a
// fixed sequence (EQ, table read, interpolation, delay memory access, comb
// mix, output gain). The next sample is accepted as soon as the sequence is
// back at rest, while the previous result still sits in the output register;
// a finished sample waits in the last step until that register is free. The
// delay memory is one single-port-write RAM tracked by a high-water mark, so
// no clearing pass is needed and the block takes samples right after reset.
// The user must write configuration through wr_en/wr_index/wr_data only while
// no sample is in flight; the block itself does not enforce this.
module audio_effects_chain
	import aec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	aec_in_if.sink           sample_ch,
	aec_out_if.source        result_ch,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data
);
	cfg_t    cfg;
	dp_cmd_t cmd;

	aec_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	aec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.in_ready  (sample_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.cmd       (cmd)
	);

	aec_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.sample_in  (sample_ch.sample_in),
		.sample_out (result_ch.sample_out),
		.clipped    (result_ch.clipped)
	);
endmodule

// File: rtl/core/aec_chk.sv
// ----------------------------------------------------------------------------
// Audio effects chain checker
// Port-level properties of the sample and result channels, bound to the top.
// ----------------------------------------------------------------------------
module aec_chk
	import aec_pkg::*;
(
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input logic                           clipped
);
	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Samples accepted whose result has not been delivered yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
		else $error("result changed or dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("sample accepted while another is being processed");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after accepting a sample");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 2'd0)
		else $error("result delivered with no sample outstanding");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> pend_q <= 2'd1)
		else $error("more than two samples outstanding");
endmodule

bind audio_effects_chain aec_chk u_aec_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_ch.valid),
	.in_ready   (sample_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.sample_out (result_ch.sample_out),
	.clipped    (result_ch.clipped)
);
